### hdl/pmvr_pkg.sv
// package for the per-material vertex remap block
// field widths, default sizes and the sequencer state type; no dependencies
package pmvr_pkg;

    localparam int VERT_W     = 16;
    localparam int MAT_IN_W   = 16;
    localparam int MAT_OUT_W  = 3;
    localparam int MASK_W     = 3;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = VERT_W + 1;
    localparam int ENTRY_W    = VERT_W + 1;
    localparam int DEF_MAX_MATERIALS = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_OUT
    } t_state;

endpackage

### hdl/pmvr_if.sv
// channel interfaces of the per-material vertex remap block
// depends on pmvr_pkg for field widths
interface pmvr_tri_if import pmvr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MAT_IN_W-1:0] material_id;
    logic [VERT_W-1:0]   vertex_a;
    logic [VERT_W-1:0]   vertex_b;
    logic [VERT_W-1:0]   vertex_c;

    modport source (output valid, material_id, vertex_a, vertex_b, vertex_c, input ready);
    modport sink   (input valid, material_id, vertex_a, vertex_b, vertex_c, output ready);
endinterface

interface pmvr_res_if import pmvr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MAT_OUT_W-1:0] material_out;
    logic [VERT_W-1:0]    new_a;
    logic [VERT_W-1:0]    new_b;
    logic [VERT_W-1:0]    new_c;
    logic [MASK_W-1:0]    first_use_mask;
    logic                 bad_material;

    modport source (output valid, material_out, new_a, new_b, new_c, first_use_mask,
                    bad_material, input ready);
    modport sink   (input valid, material_out, new_a, new_b, new_c, first_use_mask,
                    bad_material, output ready);
endinterface

interface pmvr_cfg_if import pmvr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/per_material_vertex_remap_top.sv
// per-material vertex remap: triangle in, remapped triangle out
// one single-port remap memory shared by the three vertices under a small sequencer
// depends on pmvr_pkg and the interfaces in pmvr_if.sv
//
// usage:
//  - i_in carries a triangle (material id, three vertex indices); o_out carries
//    the remapped indices, first-use mask and bad-material flag; i_cfg writes
//    material_count and is always ready
//  - each vertex goes through a read state and a check/write state on the remap
//    memory, so a good triangle passes ST_RD and ST_CHK for each vertex, then
//    ST_OUT; a rejected material id goes from ST_IDLE straight to ST_OUT
//  - one triangle is in work at a time; i_in.ready comes back as the result
//    is loaded into the output register, so a new triangle is taken only
//    after the last one is through
//  - the output register holds a finished result while o_out.ready is low;
//    the next triangle is taken and worked on meanwhile, and waits to be
//    loaded until the output register is free
//  - after reset a clearing pass writes every remap entry invalid, one entry
//    a cycle, MAX_MATERIALS * 65536 entries; i_in.ready stays low until done
//  - material_count resets to 1, all vertex counts to zero
module per_material_vertex_remap_top
    import pmvr_pkg::*;
#(
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmvr_cfg_if.sink   i_cfg,
    pmvr_tri_if.sink   i_in,
    pmvr_res_if.source o_out
);

    localparam int MAT_W  = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;
    localparam int ADDR_W = MAT_W + VERT_W;
    localparam int DEPTH  = MAX_MATERIALS * (2 ** VERT_W);
    localparam logic [ADDR_W-1:0]   CLR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [MAT_IN_W-1:0] MAX_L    = MAT_IN_W'(MAX_MATERIALS);
    localparam logic [CNT_W-1:0]    CNT_MAX  = CNT_W'(2 ** VERT_W);

    // remap memory and per-material counts
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0]   r_vcount [MAX_MATERIALS];

    t_state r_state, n_state;

    logic [CFG_W-1:0]        r_mat_count;
    logic [ADDR_W-1:0]       r_clr;
    logic [ENTRY_W-1:0]      r_rdata;
    logic [MAT_IN_W-1:0]     r_mat;
    logic [VERT_W-1:0]       r_va, r_vb, r_vc;
    logic [CNT_W-1:0]        r_cnt;
    logic [1:0]              r_vi;
    logic [2:0][VERT_W-1:0]  r_new;
    logic [MASK_W-1:0]       r_mask;
    logic                    r_bad;

    logic                 r_o_valid;
    logic [MAT_OUT_W-1:0] r_o_mat;
    logic [VERT_W-1:0]    r_o_a, r_o_b, r_o_c;
    logic [MASK_W-1:0]    r_o_mask;
    logic                 r_o_bad;

    logic                in_xfer;
    logic                out_free;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [VERT_W-1:0]   cur_v;
    logic [MAT_IN_W-1:0] limit;
    logic                in_bad;
    logic                hit;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_o_valid || o_out.ready;
    assign hit         = r_rdata[ENTRY_W-1];

    // a count above the parameter acts as the parameter
    always_comb begin
        if ({{(MAT_IN_W-CFG_W){1'b0}}, r_mat_count} > MAX_L) begin
            limit = MAX_L;
        end else begin
            limit = {{(MAT_IN_W-CFG_W){1'b0}}, r_mat_count};
        end
        in_bad = (i_in.material_id >= limit);
    end

    always_comb begin
        case (r_vi)
            2'd0:    cur_v = r_va;
            2'd1:    cur_v = r_vb;
            default: cur_v = r_vc;
        endcase
    end

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {r_mat[MAT_W-1:0], cur_v};
        mem_wdata = {1'b1, r_cnt[VERT_W-1:0]};
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = in_bad ? ST_OUT : ST_RD;
                end
            end
            ST_RD: begin
                mem_re  = 1'b1;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                mem_we  = !hit;
                n_state = (r_vi == 2'd2) ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // single-port remap memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_count <= CFG_RESET;
            r_clr       <= '0;
            r_o_valid   <= 1'b0;
            for (int m = 0; m < MAX_MATERIALS; m++) begin
                r_vcount[m] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_mat_count <= i_cfg.data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (r_state == ST_OUT && out_free) begin
                r_o_valid <= 1'b1;
                if (!r_bad) begin
                    r_vcount[r_mat[MAT_W-1:0]] <= r_cnt;
                end
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working registers of the triangle in flight
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_mat  <= i_in.material_id;
                    r_va   <= i_in.vertex_a;
                    r_vb   <= i_in.vertex_b;
                    r_vc   <= i_in.vertex_c;
                    r_bad  <= in_bad;
                    r_vi   <= 2'd0;
                    r_mask <= '0;
                    r_new  <= '0;
                    // rejected ids never use the count
                    if (!in_bad) begin
                        r_cnt <= r_vcount[i_in.material_id[MAT_W-1:0]];
                    end
                end
            end
            ST_CHK: begin
                r_vi <= r_vi + 2'd1;
                if (hit) begin
                    r_new[r_vi] <= r_rdata[VERT_W-1:0];
                end else begin
                    r_new[r_vi]  <= r_cnt[VERT_W-1:0];
                    r_mask[r_vi] <= 1'b1;
                    if (r_cnt < CNT_MAX) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_mat  <= r_bad ? '0 : r_mat[MAT_OUT_W-1:0];
            r_o_a    <= r_new[0];
            r_o_b    <= r_new[1];
            r_o_c    <= r_new[2];
            r_o_mask <= r_mask;
            r_o_bad  <= r_bad;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.material_out   = r_o_mat;
    assign o_out.new_a          = r_o_a;
    assign o_out.new_b          = r_o_b;
    assign o_out.new_c          = r_o_c;
    assign o_out.first_use_mask = r_o_mask;
    assign o_out.bad_material   = r_o_bad;

endmodule
